@@ rtl/epoch_seconds_to_calendar_macros.svh @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar assertion macros
// Shared concurrent assertion forms for the calendar converter checks.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("epoch_seconds_to_calendar: check failed");

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epoch_seconds_to_calendar: check failed");

`endif

@@ rtl/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the calendar converter controller and datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_QUAD = (365 * 4) + 1;
  localparam int unsigned DAYS_PER_YEAR = 365;

  localparam int unsigned DAYS_1900_TO_1970 = (70 * 365) + 18;
  localparam int unsigned DAYS_JAN_FEB      = 31 + 28;
  localparam int unsigned DAYS_LEAP_YEAR    = 366;
  localparam int unsigned BASE_YEAR         = 1900;

  // floor(2^32 / d): the quotient estimate is low by at most one
  localparam longint unsigned RCP_ONE = 64'h1_0000_0000;
  localparam logic [31:0] RCP_DAY  = 32'(RCP_ONE / SECS_PER_DAY);
  localparam logic [31:0] RCP_HOUR = 32'(RCP_ONE / SECS_PER_HOUR);
  localparam logic [31:0] RCP_MIN  = 32'(RCP_ONE / SECS_PER_MIN);
  localparam logic [31:0] RCP_QUAD = 32'(RCP_ONE / DAYS_PER_QUAD);
  localparam logic [31:0] RCP_YEAR = 32'(RCP_ONE / DAYS_PER_YEAR);

  // first day of each month in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] s;
    case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd60;
      4'd3:    s = 9'd91;
      4'd4:    s = 9'd121;
      4'd5:    s = 9'd152;
      4'd6:    s = 9'd182;
      4'd7:    s = 9'd213;
      4'd8:    s = 9'd244;
      4'd9:    s = 9'd274;
      4'd10:   s = 9'd305;
      4'd11:   s = 9'd335;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  typedef enum logic [2:0] {
    SEL_DAYS,
    SEL_HOUR,
    SEL_MIN,
    SEL_QUAD,
    SEL_YEAR
  } div_sel_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_SUB,
    PH_FIX
  } div_phase_t;

  typedef struct packed {
    logic       load;
    div_sel_t   sel;
    div_phase_t ph;
    logic       fin;
  } esc_cmd_t;

endpackage

@@ rtl/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to date, four-year leap rule
// Each accepted input runs five constant divisions (multiply, subtract, fix steps),
// then goes to the result register; input is refused until idle, and a stalled result holds the sequencer.
// Reset (synchronous, active high) clears the sequencer and result valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        epoch_valid,
  output logic        epoch_stall,
  input  logic [31:0] epoch_seconds,
  output logic        cal_valid,
  input  logic        cal_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month
);

  esc_cmd_t cmd;

  esc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .epoch_valid (epoch_valid),
    .epoch_stall (epoch_stall),
    .cal_valid   (cal_valid),
    .cal_stall   (cal_stall),
    .cmd         (cmd)
  );

  esc_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .epoch_seconds (epoch_seconds),
    .second        (second),
    .minute        (minute),
    .hour          (hour),
    .weekday       (weekday),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month)
  );

endmodule

@@ rtl/esc_ctrl.sv @@
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer for the calendar converter: runs the chain of constant divisions,
// three steps each, and hands the finished item to the output register.
// ----------------------------------------------------------------------------
module esc_ctrl import esc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     epoch_valid,
  output logic     epoch_stall,
  output logic     cal_valid,
  input  logic     cal_stall,
  output esc_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DAYS = 7'b0000010,
    S_HOUR = 7'b0000100,
    S_MIN  = 7'b0001000,
    S_QUAD = 7'b0010000,
    S_YEAR = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  div_phase_t ph, ph_next, ph_adv;

  assign epoch_stall = rst || (state != S_IDLE);

  always_comb begin
    case (ph)
      PH_MUL:  ph_adv = PH_SUB;
      PH_SUB:  ph_adv = PH_FIX;
      default: ph_adv = PH_MUL;
    endcase
  end

  always_comb begin
    state_next = state;
    ph_next    = ph;
    cmd        = '{load: 1'b0, sel: SEL_DAYS, ph: PH_IDLE, fin: 1'b0};
    case (state)
      S_IDLE: begin
        if (epoch_valid) begin
          cmd.load   = 1'b1;
          ph_next    = PH_MUL;
          state_next = S_DAYS;
        end
      end
      S_DAYS: begin
        cmd.sel = SEL_DAYS;
        cmd.ph  = ph;
        ph_next = ph_adv;
        if (ph == PH_FIX) state_next = S_HOUR;
      end
      S_HOUR: begin
        cmd.sel = SEL_HOUR;
        cmd.ph  = ph;
        ph_next = ph_adv;
        if (ph == PH_FIX) state_next = S_MIN;
      end
      S_MIN: begin
        cmd.sel = SEL_MIN;
        cmd.ph  = ph;
        ph_next = ph_adv;
        if (ph == PH_FIX) state_next = S_QUAD;
      end
      S_QUAD: begin
        cmd.sel = SEL_QUAD;
        cmd.ph  = ph;
        ph_next = ph_adv;
        if (ph == PH_FIX) state_next = S_YEAR;
      end
      S_YEAR: begin
        cmd.sel = SEL_YEAR;
        cmd.ph  = ph;
        ph_next = ph_adv;
        if (ph == PH_FIX) begin
          ph_next    = PH_IDLE;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!cal_valid || !cal_stall) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        ph_next    = PH_IDLE;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= PH_IDLE;
      cal_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      if (cmd.fin) begin
        cal_valid <= 1'b1;
      end else if (!cal_stall) begin
        cal_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/esc_dp.sv @@
// ----------------------------------------------------------------------------
// esc_dp
// Datapath for the calendar converter: one shared reciprocal-multiply divider
// by constant divisors, weekday fold, month lookup and the output register.
// ----------------------------------------------------------------------------
module esc_dp import esc_pkg::*; (
  input  logic        clk,
  input  esc_cmd_t    cmd,
  input  logic [31:0] epoch_seconds,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month
);

  function automatic logic [2:0] mod7(input logic [16:0] v);
    logic [17:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    w  = {1'b0, v};
    s1 = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9])
       + 6'(w[14:12]) + 6'(w[17:15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  logic [31:0] dvd, quo, rem;
  logic [15:0] days;
  logic [4:0]  hour_r;
  logic [5:0]  min_r, sec_r;
  logic [2:0]  wday_r;
  logic [5:0]  quad_r;
  logic        long_r;
  logic [1:0]  yoff;
  logic [8:0]  doy;

  logic [31:0] div_k, rcp_k;
  logic [63:0] prod;
  logic        fix_up;
  logic [31:0] q_fix, r_fix;
  logic [16:0] dnum;
  logic        long_yr;

  always_comb begin
    case (cmd.sel)
      SEL_DAYS: begin
        div_k = 32'(SECS_PER_DAY);
        rcp_k = RCP_DAY;
      end
      SEL_HOUR: begin
        div_k = 32'(SECS_PER_HOUR);
        rcp_k = RCP_HOUR;
      end
      SEL_MIN: begin
        div_k = 32'(SECS_PER_MIN);
        rcp_k = RCP_MIN;
      end
      SEL_QUAD: begin
        div_k = 32'(DAYS_PER_QUAD);
        rcp_k = RCP_QUAD;
      end
      SEL_YEAR: begin
        div_k = 32'(DAYS_PER_YEAR);
        rcp_k = RCP_YEAR;
      end
      default: begin
        div_k = 32'(SECS_PER_DAY);
        rcp_k = RCP_DAY;
      end
    endcase
  end

  assign prod    = 64'(dvd) * 64'(rcp_k);
  assign fix_up  = (rem >= div_k);
  assign q_fix   = fix_up ? (quo + 32'd1) : quo;
  assign r_fix   = fix_up ? (rem - div_k) : rem;
  assign dnum    = 17'(days) + 17'(DAYS_1900_TO_1970);
  assign long_yr = (r_fix >= 32'(DAYS_LEAP_YEAR));

  // day of year to month and day
  logic [8:0]  dy_adj, dom;
  logic [3:0]  mon_idx;

  always_comb begin
    dy_adj  = ((yoff != 2'd0) && (doy >= 9'(DAYS_JAN_FEB))) ? (doy + 9'd1) : doy;
    mon_idx = '0;
    for (int k = 1; k < 12; k++) begin
      if (dy_adj >= month_start(4'(k))) mon_idx = 4'(k);
    end
    dom = dy_adj - month_start(mon_idx);
  end

  always_ff @(posedge clk) begin
    case (cmd.ph)
      PH_MUL: begin
        quo <= prod[63:32];
      end
      PH_SUB: begin
        rem <= dvd - quo * div_k;
      end
      PH_FIX: begin
        case (cmd.sel)
          SEL_DAYS: begin
            days <= q_fix[15:0];
            dvd  <= r_fix;
          end
          SEL_HOUR: begin
            hour_r <= q_fix[4:0];
            dvd    <= r_fix;
          end
          SEL_MIN: begin
            min_r  <= q_fix[5:0];
            sec_r  <= r_fix[5:0];
            wday_r <= mod7(dnum);
            dvd    <= 32'(dnum);
          end
          SEL_QUAD: begin
            quad_r <= q_fix[5:0];
            long_r <= long_yr;
            dvd    <= long_yr ? (r_fix - 32'd1) : r_fix;
          end
          SEL_YEAR: begin
            // leap first year of the quad: the day count is already the day of year
            yoff <= long_r ? q_fix[1:0] : 2'd0;
            doy  <= long_r ? r_fix[8:0] : dvd[8:0];
          end
          default: begin
            dvd <= dvd;
          end
        endcase
      end
      default: begin
        if (cmd.load) dvd <= epoch_seconds;
      end
    endcase
    if (cmd.fin) begin
      second       <= sec_r;
      minute       <= min_r;
      hour         <= hour_r;
      weekday      <= wday_r;
      year         <= 12'(BASE_YEAR) + {4'd0, quad_r, yoff};
      month        <= mon_idx + 4'd1;
      day_of_month <= 5'(dom + 9'd1);
    end
  end

endmodule

@@ rtl/esc_checker.sv @@
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for the calendar converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_macros.svh"

module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        epoch_valid,
  input logic        epoch_stall,
  input logic        cal_valid,
  input logic        cal_stall,
  input logic [5:0]  second,
  input logic [5:0]  minute,
  input logic [4:0]  hour,
  input logic [2:0]  weekday,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month
);

  `ESC_ASSERT_NEXT(a_busy_after_accept, clk, rst, epoch_valid && !epoch_stall, epoch_stall)
  `ESC_ASSERT_NOW(a_time_range, clk, rst, cal_valid, (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) && (weekday < 3'd7))
  `ESC_ASSERT_NOW(a_date_range, clk, rst, cal_valid, (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0) && (year >= 12'd1970) && (year <= 12'd2106))
  `ESC_ASSERT_NEXT(a_out_hold, clk, rst, cal_valid && cal_stall, cal_valid && $stable(year) && $stable(month) && $stable(day_of_month) && $stable(second))

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk          (clk),
  .rst          (rst),
  .epoch_valid  (epoch_valid),
  .epoch_stall  (epoch_stall),
  .cal_valid    (cal_valid),
  .cal_stall    (cal_stall),
  .second       (second),
  .minute       (minute),
  .hour         (hour),
  .weekday      (weekday),
  .year         (year),
  .month        (month),
  .day_of_month (day_of_month)
);
